### src/vnu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnu_pkg
// Shared widths and types of the vector normalisation pipeline.
// ----------------------------------------------------------------------------
package vnu_pkg;

    localparam int InW      = 24;  // Q8.16 component width
    localparam int UnitW    = 18;  // Q1.16 unit component width
    localparam int QuotW    = 17;  // unsigned unit magnitude width
    localparam int SumW     = 48;  // sum of squares width
    localparam int RadW     = 64;  // radicand width, sum scaled by 2^16
    localparam int RootW    = 32;  // square root width
    localparam int SqRemW   = 34;  // square root partial remainder width
    localparam int DivRemW  = 33;  // divider partial remainder width
    localparam int NumW     = 50;  // dividend width
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 17;

    // Signs and magnitudes that travel beside the arithmetic.
    typedef struct packed {
        logic [2:0]           neg;
        logic [2:0][InW-1:0]  mag;
    } t_side;

endpackage : vnu_pkg
`default_nettype wire

### src/vec3_normalize_unit.sv
// Pipeline: 3 square and sum stages, 32 square root stages, 17 divider stages
// and 1 output register lie between input transfer and result.
// Throughput: one vector per cycle; the whole pipeline advances together and
// holds while the output register carries a result that is not taken.
// Reset: i_rst_n, synchronous and active low, clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_normalize_unit
// Pipelined normalisation of a Q8.16 three-component vector to Q1.16.
// ----------------------------------------------------------------------------
module vec3_normalize_unit
    import vnu_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [71:0]  i_s_axis_tdata,  // x_in, y_in, z_in
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [79:0]       o_m_axis_tdata,  // unit_x, unit_y, unit_z, length_out, zeros
    output logic              o_m_axis_tuser   // zero_length
);

    logic                    en;
    logic                    ss_valid, sq_valid, dv_valid;
    t_side                   ss_side, sq_side;
    logic [SumW-1:0]         ss_sum;
    logic [RootW-1:0]        sq_root, dv_root;
    logic [2:0]              dv_neg;
    logic [2:0][QuotW-1:0]   dv_quot;
    logic [2:0][InW-1:0]     comp;

    logic                    r_out_valid;
    logic [2:0][UnitW-1:0]   r_unit;
    logic [InW-1:0]          r_length;
    logic                    r_zero;
    logic                    n_zero;
    logic [RootW:0]          len_sum;

    // The pipeline moves whenever the output register is free or drained.
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign comp[0] = i_s_axis_tdata[23:0];
    assign comp[1] = i_s_axis_tdata[47:24];
    assign comp[2] = i_s_axis_tdata[71:48];

    vnu_square_sum u_square_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_comp  (comp),
        .o_valid (ss_valid),
        .o_side  (ss_side),
        .o_sum   (ss_sum)
    );

    vnu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ss_valid),
        .i_side  (ss_side),
        .i_sum   (ss_sum),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    vnu_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_root  (sq_root),
        .o_valid (dv_valid),
        .o_neg   (dv_neg),
        .o_root  (dv_root),
        .o_quot  (dv_quot)
    );

    // A nonzero vector always has a root of at least 256.
    assign n_zero  = (dv_root == '0);
    assign len_sum = {1'b0, dv_root} + (RootW + 1)'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    // Output register: signs restored, zero vector forced to zero.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero   <= n_zero;
            r_length <= len_sum[RootW-1:8];
            for (int l = 0; l < 3; l++) begin
                if (n_zero) begin
                    r_unit[l] <= '0;
                end else if (dv_neg[l]) begin
                    r_unit[l] <= -{1'b0, dv_quot[l]};
                end else begin
                    r_unit[l] <= {1'b0, dv_quot[l]};
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_length, r_unit[2], r_unit[1], r_unit[0]};
    assign o_m_axis_tuser  = r_zero;

    // A zero vector yields zero components and zero length.
    a_zero_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_zero) |-> (o_m_axis_tdata == '0))
        else $error("zero vector gave a nonzero result");

    // A nonzero vector always has a nonzero length.
    a_length_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_zero) |-> (r_length != '0))
        else $error("nonzero vector gave zero length");

    // Unit components stay within plus and minus one.
    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_unit[0]) <= 18'sd65536 && $signed(r_unit[0]) >= -18'sd65536
            && $signed(r_unit[1]) <= 18'sd65536 && $signed(r_unit[1]) >= -18'sd65536
            && $signed(r_unit[2]) <= 18'sd65536 && $signed(r_unit[2]) >= -18'sd65536))
        else $error("unit component out of range");

endmodule : vec3_normalize_unit
`default_nettype wire

### src/vnu_square_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnu_square_sum
// Three stages: component magnitudes, squares, and the sum of squares.
// ----------------------------------------------------------------------------
module vnu_square_sum
    import vnu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2:0][InW-1:0]   i_comp,
    output logic                       o_valid,
    output t_side                      o_side,
    output logic [SumW-1:0]            o_sum
);

    logic                   r_va, r_vb, r_vc;
    t_side                  r_side_a, r_side_b, r_side_c;
    t_side                  n_side_a;
    logic [2:0][SumW-1:0]   r_sq;
    logic [SumW-1:0]        r_sum;

    // Magnitudes of the two's complement components.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_side_a.neg[i] = i_comp[i][InW-1];
            n_side_a.mag[i] = i_comp[i][InW-1] ? InW'(-i_comp[i]) : i_comp[i];
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Data path of the three stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a <= n_side_a;
            r_side_b <= r_side_a;
            r_side_c <= r_side_b;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_side_a.mag[i] * r_side_a.mag[i];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_valid = r_vc;
    assign o_side  = r_side_c;
    assign o_sum   = r_sum;

endmodule : vnu_square_sum
`default_nettype wire

### src/vnu_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnu_sqrt
// Restoring integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module vnu_sqrt
    import vnu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_side              i_side,
    input  wire logic [SumW-1:0]    i_sum,
    output logic                    o_valid,
    output t_side                   o_side,
    output logic [RootW-1:0]        o_root
);

    logic                 r_v    [SqrtSteps];
    t_side                r_side [SqrtSteps];
    logic [SqRemW-1:0]    r_rem  [SqrtSteps];
    logic [RootW-1:0]     r_root [SqrtSteps];
    logic [RadW-1:0]      r_rad  [SqrtSteps];

    for (genvar s = 0; s < SqrtSteps; s++) begin : g_stage
        logic              p_v;
        t_side             p_side;
        logic [SqRemW-1:0] p_rem, t_rem, trial;
        logic [RootW-1:0]  p_root;
        logic [RadW-1:0]   p_rad;

        // Previous stage, or the radicand entering the root.
        if (s == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = {i_sum, (RadW - SumW)'(0)};
        end else begin : g_next
            assign p_v    = r_v[s-1];
            assign p_side = r_side[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_rad  = r_rad[s-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign t_rem = {p_rem[SqRemW-3:0], p_rad[RadW-1 -: 2]};
        assign trial = {p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= p_side;
                r_rad[s]  <= {p_rad[RadW-3:0], 2'b00};
                if (t_rem >= trial) begin
                    r_rem[s]  <= t_rem - trial;
                    r_root[s] <= {p_root[RootW-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= t_rem;
                    r_root[s] <= {p_root[RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[SqrtSteps-1];
    assign o_side  = r_side[SqrtSteps-1];
    assign o_root  = r_root[SqrtSteps-1];

endmodule : vnu_sqrt
`default_nettype wire

### src/vnu_divide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnu_divide
// Three-lane restoring divider, one quotient bit per stage, that forms
// the rounded unit magnitudes (a * 2^25 + R) / (2 * R).
// ----------------------------------------------------------------------------
module vnu_divide
    import vnu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_side                i_side,
    input  wire logic [RootW-1:0]     i_root,
    output logic                      o_valid,
    output logic [2:0]                o_neg,
    output logic [RootW-1:0]          o_root,
    output logic [2:0][QuotW-1:0]     o_quot
);

    logic                        r_v    [DivSteps];
    logic [2:0]                  r_neg  [DivSteps];
    logic [RootW-1:0]            r_root [DivSteps];
    logic [2:0][DivRemW-1:0]     r_rem  [DivSteps];
    logic [2:0][QuotW-1:0]       r_low  [DivSteps];
    logic [2:0][QuotW-1:0]       r_quot [DivSteps];

    for (genvar s = 0; s < DivSteps; s++) begin : g_stage
        logic                    p_v;
        logic [2:0]              p_neg;
        logic [RootW-1:0]        p_root;
        logic [2:0][DivRemW-1:0] p_rem;
        logic [2:0][QuotW-1:0]   p_low;
        logic [2:0][QuotW-1:0]   p_quot;
        logic [DivRemW-1:0]      dvs;

        if (s == 0) begin : g_first
            logic [2:0][NumW-1:0] num;
            // Dividend split into the leading remainder and the bits to come.
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign num[l]   = NumW'({i_side.mag[l], 25'd0}) + NumW'(i_root);
                assign p_rem[l] = num[l][NumW-1 -: DivRemW];
                assign p_low[l] = num[l][QuotW-1:0];
            end
            assign p_v    = i_valid;
            assign p_neg  = i_side.neg;
            assign p_root = i_root;
            assign p_quot = '0;
        end else begin : g_next
            assign p_v    = r_v[s-1];
            assign p_neg  = r_neg[s-1];
            assign p_root = r_root[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_low  = r_low[s-1];
            assign p_quot = r_quot[s-1];
        end

        assign dvs = {p_root, 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        // One trial subtraction in each lane.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[s]  <= p_neg;
                r_root[s] <= p_root;
                for (int l = 0; l < 3; l++) begin
                    logic [DivRemW:0] t_rem;
                    t_rem = {p_rem[l], p_low[l][QuotW-1]};
                    r_low[s][l] <= {p_low[l][QuotW-2:0], 1'b0};
                    if (t_rem >= {1'b0, dvs}) begin
                        r_rem[s][l]  <= DivRemW'(t_rem - {1'b0, dvs});
                        r_quot[s][l] <= {p_quot[l][QuotW-2:0], 1'b1};
                    end else begin
                        r_rem[s][l]  <= t_rem[DivRemW-1:0];
                        r_quot[s][l] <= {p_quot[l][QuotW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_v[DivSteps-1];
    assign o_neg   = r_neg[DivSteps-1];
    assign o_root  = r_root[DivSteps-1];
    assign o_quot  = r_quot[DivSteps-1];

endmodule : vnu_divide
`default_nettype wire
